// ===== sv/mutex_lock_table_assert.svh =====
// Assertion macros for the RTL of the mutex lock table.
`ifndef MUTEX_LOCK_TABLE_ASSERT_SVH
`define MUTEX_LOCK_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MLT_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mutex lock table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MLT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mutex lock table: next-cycle check failed");

`endif

// ===== sv/mlt_pkg.sv =====
package mlt_pkg;

   // table geometry
   localparam int MUTEX_COUNT = 16;
   localparam int INDEX_BITS  = 4;
   localparam int ENTRY_BITS  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
   localparam int COUNT_BITS  = 11;
   localparam int TID_BITS    = 16;
   localparam int WORD_BITS   = 16;

   // lock word layout
   localparam int CNT_SHIFT   = 2;
   localparam int SHARED_BIT  = 13;
   localparam int TYPE_LSB    = 14;

   localparam logic [WORD_BITS-1:0] W_DESTROYED = 16'hffff;
   localparam logic [WORD_BITS-1:0] W_CNT_ONE   = WORD_BITS'(1) << CNT_SHIFT;

   localparam logic [1:0] LS_UNLOCKED  = 2'd0;
   localparam logic [1:0] LS_LOCKED    = 2'd1;
   localparam logic [1:0] LS_CONTENDED = 2'd2;

   localparam logic [1:0] MT_NORMAL     = 2'd0;
   localparam logic [1:0] MT_RECURSIVE  = 2'd1;
   localparam logic [1:0] MT_ERRORCHECK = 2'd2;

   // request codes
   localparam logic [1:0] FUNC_INIT    = 2'd0;
   localparam logic [1:0] FUNC_LOCK    = 2'd1;
   localparam logic [1:0] FUNC_UNLOCK  = 2'd2;
   localparam logic [1:0] FUNC_DESTROY = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BUSY      = 3'd1;
   localparam logic [2:0] ST_AGAIN     = 3'd2;
   localparam logic [2:0] ST_DEADLOCK  = 3'd3;
   localparam logic [2:0] ST_NOTOWNER  = 3'd4;
   localparam logic [2:0] ST_INVALID   = 3'd5;
   localparam logic [2:0] ST_DESTROYED = 3'd6;
   localparam logic [2:0] ST_WAIT      = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  mutex_index;
      logic        handle_valid;
      logic [15:0] caller_id;
      logic        attr_present;
      logic        attr_shared;
      logic [3:0]  attr_type;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       wake_one;
   } rsp_type;

   typedef struct packed {
      logic [TID_BITS-1:0]  owner;
      logic [WORD_BITS-1:0] word;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      entry_type entry;
      rsp_type   rsp;
   } upd_type;

endpackage

// ===== sv/mlt_update.sv =====
module mlt_update (
   input  mlt_pkg::req_type   req,
   input  mlt_pkg::entry_type cur,
   output mlt_pkg::upd_type   upd
);
   import mlt_pkg::*;

   localparam logic [INDEX_BITS:0] INDEX_LIMIT = (INDEX_BITS+1)'(MUTEX_COUNT);

   logic [WORD_BITS-1:0]  w;
   logic [1:0]            mtype;
   logic                  sh;
   logic [1:0]            lstate;
   logic [COUNT_BITS-1:0] cnt;
   logic [TID_BITS-1:0]   tid;
   logic                  in_range;
   logic                  is_owner;

   assign w        = cur.word;
   assign mtype    = w[TYPE_LSB +: 2];
   assign sh       = w[SHARED_BIT];
   assign lstate   = w[1:0];
   assign cnt      = w[CNT_SHIFT +: COUNT_BITS];
   assign tid      = req.caller_id[TID_BITS-1:0];
   assign in_range = {1'b0, req.mutex_index} < INDEX_LIMIT;
   assign is_owner = (lstate != LS_UNLOCKED) && (tid == cur.owner);

   // work out the new entry and the result for one request
   always_comb begin
      upd = '0;
      upd.entry = cur;
      upd.rsp.status = ST_OK;
      if (!req.handle_valid || !in_range) begin
         upd.rsp.status = ST_INVALID;
      end else begin
         upd.wr_en = 1'b1;
         case (req.func)
            FUNC_INIT: begin
               upd.entry = '0;
               if (req.attr_present) begin
                  if (req.attr_type inside {4'd0, 4'd1, 4'd2}) begin
                     upd.entry.word[SHARED_BIT] = req.attr_shared;
                     upd.entry.word[TYPE_LSB +: 2] = req.attr_type[1:0];
                  end else begin
                     upd.rsp.status = ST_INVALID;
                  end
               end
            end
            FUNC_LOCK: begin
               if (w == W_DESTROYED) begin
                  upd.rsp.status = ST_DESTROYED;
               end else if (mtype == MT_NORMAL) begin
                  upd.entry.word = '0;
                  upd.entry.word[SHARED_BIT] = sh;
                  if (lstate == LS_UNLOCKED) begin
                     upd.entry.word[1:0] = LS_LOCKED;
                  end else begin
                     upd.entry.word[1:0] = LS_CONTENDED;
                     upd.rsp.status = ST_WAIT;
                  end
               end else if (is_owner) begin
                  if (mtype == MT_ERRORCHECK) begin
                     upd.rsp.status = ST_DEADLOCK;
                  end else if (&cnt) begin
                     upd.rsp.status = ST_AGAIN;
                  end else begin
                     upd.entry.word = w + W_CNT_ONE;
                  end
               end else if (lstate == LS_UNLOCKED) begin
                  upd.entry.word = '0;
                  upd.entry.word[TYPE_LSB +: 2] = mtype;
                  upd.entry.word[SHARED_BIT] = sh;
                  upd.entry.word[1:0] = LS_LOCKED;
                  upd.entry.owner = tid;
               end else begin
                  if (lstate == LS_LOCKED) begin
                     upd.entry.word[1:0] = LS_CONTENDED;
                  end
                  upd.rsp.status = ST_WAIT;
               end
            end
            FUNC_UNLOCK: begin
               if (w == W_DESTROYED) begin
                  upd.rsp.status = ST_DESTROYED;
               end else if (mtype == MT_NORMAL) begin
                  upd.entry.word = '0;
                  upd.entry.word[SHARED_BIT] = sh;
                  upd.rsp.wake_one = (lstate == LS_CONTENDED);
               end else if (!is_owner) begin
                  upd.rsp.status = ST_NOTOWNER;
               end else if (cnt != '0) begin
                  upd.entry.word = w - W_CNT_ONE;
               end else begin
                  upd.entry.owner = '0;
                  upd.entry.word = '0;
                  upd.entry.word[TYPE_LSB +: 2] = mtype;
                  upd.entry.word[SHARED_BIT] = sh;
                  upd.rsp.wake_one = (lstate == LS_CONTENDED);
               end
            end
            default: begin
               // destroy
               if (w == W_DESTROYED) begin
                  upd.rsp.status = ST_DESTROYED;
               end else if (lstate == LS_UNLOCKED) begin
                  upd.entry.word = W_DESTROYED;
               end else begin
                  upd.rsp.status = ST_BUSY;
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/mutex_lock_table.sv =====
// Flow: a taken request moves into the update stage with its table read; then
// its update is written back and its result goes into the output register.
// Throughput: one request per cycle while the input is not stalled; a write to
// the entry the next request reads is forwarded around the table memory.
// Reset: entry valid bits clear at once, so every mutex reads as a normal,
// private, unlocked mutex with no owner; the pipeline and output empty.
`include "mutex_lock_table_assert.svh"

module mutex_lock_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mlt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mlt_pkg::rsp_type rsp_data
);
   import mlt_pkg::*;

   entry_type              table_mem [MUTEX_COUNT];
   logic [MUTEX_COUNT-1:0] ent_valid_ff;

   logic                   s1_valid_ff;
   req_type                s1_req_ff;
   entry_type              rd_entry_ff;
   logic                   rd_valid_ff;
   logic                   fwd_hit_ff;
   entry_type              fwd_entry_ff;

   logic                   out_valid_ff;
   rsp_type                out_data_ff;

   logic                   advance;
   logic                   req_accept;
   logic                   wr_en;
   logic [ENTRY_BITS-1:0]  wr_idx;
   logic [ENTRY_BITS-1:0]  rd_idx;
   entry_type              cur_entry;
   upd_type                upd;

   assign advance    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = advance && upd.wr_en;
   assign wr_idx     = s1_req_ff.mutex_index[ENTRY_BITS-1:0];
   assign rd_idx     = req_data.mutex_index[ENTRY_BITS-1:0];

   // pick forwarded, stored or reset value of the entry
   always_comb begin
      if (fwd_hit_ff) begin
         cur_entry = fwd_entry_ff;
      end else if (rd_valid_ff) begin
         cur_entry = rd_entry_ff;
      end else begin
         cur_entry = '0;
      end
   end

   mlt_update u_update (
      .req (s1_req_ff),
      .cur (cur_entry),
      .upd (upd)
   );

   // table memory: write back the update, read for the next item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx] <= upd.entry;
      end
      if (req_accept) begin
         rd_entry_ff  <= table_mem[rd_idx];
         fwd_entry_ff <= upd.entry;
         s1_req_ff    <= req_data;
      end
   end

   // entry valid bits and read-side flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            ent_valid_ff[wr_idx] <= 1'b1;
         end
         if (req_accept) begin
            rd_valid_ff <= ent_valid_ff[rd_idx];
            fwd_hit_ff  <= wr_en && (wr_idx == rd_idx);
         end
      end
   end

   // advance the item through the update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= upd.rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `MLT_ASSERT_NOW(a_wake, clock, reset, rsp_valid && rsp_data.wake_one, rsp_data.status == ST_OK)
   `MLT_ASSERT_NOW(a_write_in_stage, clock, reset, wr_en, s1_valid_ff)
   `MLT_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff)
   `MLT_ASSERT_NEXT(a_write_sets_valid, clock, reset, wr_en, ent_valid_ff[$past(wr_idx)])

endmodule

// ===== verif/mutex_lock_table_checker.sv =====
module mutex_lock_table_checker
   import mlt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   // Shadow copy of the mutex table
   logic [WORD_BITS-1:0] word_tbl  [MUTEX_COUNT];
   logic [TID_BITS-1:0]  owner_tbl [MUTEX_COUNT];

   // Results still owed by the block, oldest first
   rsp_type owed_results [$];
   int      mismatches;

   // Apply one request to the shadow table and return the result it must give
   function automatic rsp_type apply_request(req_type rq);
      rsp_type              r;
      logic [WORD_BITS-1:0] w;
      logic [1:0]           mtype;
      logic [1:0]           lstate;
      logic                 shared;
      logic [COUNT_BITS-1:0] depth;
      int                   m;
      r.status   = ST_OK;
      r.wake_one = 1'b0;
      m = int'(rq.mutex_index);
      if (!rq.handle_valid || m >= MUTEX_COUNT) begin
         r.status = ST_INVALID;
         return r;
      end
      w      = word_tbl[m];
      mtype  = w[TYPE_LSB +: 2];
      shared = w[SHARED_BIT];
      lstate = w[1:0];
      depth  = w[CNT_SHIFT +: COUNT_BITS];
      case (rq.func)
         FUNC_INIT: begin
            // clear first; a bad type still leaves the entry cleared
            word_tbl[m]  = '0;
            owner_tbl[m] = '0;
            if (rq.attr_present) begin
               if (rq.attr_type > 4'(MT_ERRORCHECK))
                  r.status = ST_INVALID;
               else
                  word_tbl[m] = {rq.attr_type[1:0], rq.attr_shared, {COUNT_BITS{1'b0}},
                                 LS_UNLOCKED};
            end
         end
         FUNC_LOCK: begin
            if (w == W_DESTROYED) begin
               r.status = ST_DESTROYED;
            end else if (mtype == MT_NORMAL) begin
               // normal mutex keeps no owner
               if (lstate == LS_UNLOCKED) begin
                  word_tbl[m] = {MT_NORMAL, shared, {COUNT_BITS{1'b0}}, LS_LOCKED};
               end else begin
                  word_tbl[m] = {MT_NORMAL, shared, {COUNT_BITS{1'b0}}, LS_CONTENDED};
                  r.status    = ST_WAIT;
               end
            end else if (lstate != LS_UNLOCKED && rq.caller_id == owner_tbl[m]) begin
               // relock by the owner
               if (mtype == MT_ERRORCHECK)
                  r.status = ST_DEADLOCK;
               else if (&depth)
                  r.status = ST_AGAIN;
               else
                  word_tbl[m] = w + W_CNT_ONE;
            end else if (lstate == LS_UNLOCKED) begin
               word_tbl[m]  = {mtype, shared, {COUNT_BITS{1'b0}}, LS_LOCKED};
               owner_tbl[m] = rq.caller_id;
            end else begin
               if (lstate == LS_LOCKED)
                  word_tbl[m] = {w[WORD_BITS-1:2], LS_CONTENDED};
               r.status = ST_WAIT;
            end
         end
         FUNC_UNLOCK: begin
            if (w == W_DESTROYED) begin
               r.status = ST_DESTROYED;
            end else if (mtype == MT_NORMAL) begin
               word_tbl[m] = {MT_NORMAL, shared, {COUNT_BITS{1'b0}}, LS_UNLOCKED};
               r.wake_one  = (lstate == LS_CONTENDED);
            end else if (lstate == LS_UNLOCKED || rq.caller_id != owner_tbl[m]) begin
               r.status = ST_NOTOWNER;
            end else if (depth != '0) begin
               word_tbl[m] = w - W_CNT_ONE;
            end else begin
               // last release: drop the owner and wake a waiter if contended
               owner_tbl[m] = '0;
               word_tbl[m]  = {mtype, shared, {COUNT_BITS{1'b0}}, LS_UNLOCKED};
               r.wake_one   = (lstate == LS_CONTENDED);
            end
         end
         default: begin
            if (w == W_DESTROYED)
               r.status = ST_DESTROYED;
            else if (lstate == LS_UNLOCKED)
               word_tbl[m] = W_DESTROYED;
            else
               r.status = ST_BUSY;
         end
      endcase
      return r;
   endfunction

   // Count a failure; print only the first few
   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected status %0d wake %0d, got status %0d wake %0d",
                  $realtime, what, want.status, want.wake_one, got.status, got.wake_one);
   endtask

   // Check results against the oldest owed one, then predict newly taken items
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < MUTEX_COUNT; i++) begin
            word_tbl[i]  = '0;
            owner_tbl[i] = '0;
         end
         owed_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               note_mismatch("result with no request outstanding", '0, rsp_data);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.wake_one !== want.wake_one)
                  note_mismatch("result mismatch", want, rsp_data);
            end
         end
         if (req_valid && !req_stall)
            owed_results.push_back(apply_request(req_data));
      end
      fail_count    <= mismatches;
      pending_count <= owed_results.size();
   end

endmodule

// ===== verif/mutex_lock_table_tb.sv =====
module mutex_lock_table_tb;
   import mlt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   int          burst_left = 0;
   int          items_sent = 0;
   logic [15:0] thread_pool [4] = '{16'h0000, 16'hffff, 16'h5a5a, 16'h00a5};

   mutex_lock_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   mutex_lock_table_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic req_type make_req(logic [1:0] func, logic [3:0] idx, logic hv,
                                        logic [15:0] tid, logic ap, logic as,
                                        logic [3:0] at);
      req_type rq;
      rq.func         = func;
      rq.mutex_index  = idx;
      rq.handle_valid = hv;
      rq.caller_id    = tid;
      rq.attr_present = ap;
      rq.attr_shared  = as;
      rq.attr_type    = at;
      return rq;
   endfunction

   function automatic logic [15:0] pick_thread();
      if ($urandom_range(0, 9) == 0)
         return 16'($urandom);
      return thread_pool[$urandom_range(0, 3)];
   endfunction

   // Mostly valid handles on a few hot entries so that threads collide
   function automatic req_type random_request();
      req_type rq;
      int      pick;
      rq.handle_valid = ($urandom_range(0, 99) < 95);
      rq.mutex_index  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                                   : 4'($urandom_range(0, 15));
      rq.caller_id    = pick_thread();
      rq.attr_present = ($urandom_range(0, 99) < 85);
      rq.attr_shared  = 1'($urandom_range(0, 1));
      rq.attr_type    = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 2))
                                                    : 4'($urandom_range(3, 15));
      pick = $urandom_range(0, 99);
      if (pick < 12)
         rq.func = FUNC_INIT;
      else if (pick < 52)
         rq.func = FUNC_LOCK;
      else if (pick < 92)
         rq.func = FUNC_UNLOCK;
      else
         rq.func = FUNC_DESTROY;
      return rq;
   endfunction

   // Offer one item and hold it until taken; idle between bursts
   task automatic offer(input req_type rq);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Receiver: stall pattern that changes mode, plus one long hold-off
   initial begin
      int mode;
      int mode_left;
      int cyc;
      rsp_stall = 1'b0;
      mode      = 0;
      mode_left = 0;
      cyc       = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 400) begin
            // hold off long enough for the block to fill and stall its input
            rsp_stall <= 1'b1;
            repeat (150) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= cyc[0];
            endcase
         end
      end
   end

   // Stimulus and verdict
   initial begin
      logic [3:0]  idx;
      logic [15:0] tid;
      int          depth;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // null handles
      offer(make_req(FUNC_LOCK, 4'd0, 1'b0, 16'h0001, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_INIT, 4'd15, 1'b0, 16'hffff, 1'b1, 1'b1, 4'd1));
      // normal mutex from reset: lock, contend, wake, unlock when not locked
      offer(make_req(FUNC_LOCK, 4'd0, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd0, 1'b1, 16'h0001, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd0, 1'b1, 16'h0002, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd0, 1'b1, 16'h0002, 1'b0, 1'b0, 4'd0));
      // recursive shared mutex, thread id zero as owner
      offer(make_req(FUNC_INIT, 4'd1, 1'b1, 16'h0000, 1'b1, 1'b1, 4'd1));
      offer(make_req(FUNC_UNLOCK, 4'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd1, 1'b1, 16'h0005, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd1, 1'b1, 16'h0005, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd1, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));
      // error-checking mutex: deadlock, busy destroy, destroyed entry
      offer(make_req(FUNC_INIT, 4'd2, 1'b1, 16'h0000, 1'b1, 1'b0, 4'd2));
      offer(make_req(FUNC_LOCK, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_DESTROY, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_DESTROY, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_DESTROY, 4'd2, 1'b1, 16'hffff, 1'b0, 1'b0, 4'd0));
      // bad init type, then re-init of a destroyed entry
      offer(make_req(FUNC_INIT, 4'd3, 1'b1, 16'h0000, 1'b1, 1'b1, 4'd15));
      offer(make_req(FUNC_INIT, 4'd2, 1'b1, 16'h0000, 1'b0, 1'b0, 4'd0));

      // drive a recursive count to its ceiling and past it
      offer(make_req(FUNC_INIT, 4'd4, 1'b1, 16'h8001, 1'b1, 1'b0, 4'd1));
      repeat (2050) offer(make_req(FUNC_LOCK, 4'd4, 1'b1, 16'h8001, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_LOCK, 4'd4, 1'b1, 16'h7ffe, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_UNLOCK, 4'd4, 1'b1, 16'h8001, 1'b0, 1'b0, 4'd0));
      offer(make_req(FUNC_INIT, 4'd4, 1'b1, 16'h8001, 1'b1, 1'b0, 4'd0));

      // random part: lock/unlock nests with a rival mixed into noise; the count
      // ceiling above already sends most of the items of the run
      items_sent = 0;
      while (items_sent < 200) begin
         if ($urandom_range(0, 2) == 0) begin
            idx   = 4'($urandom_range(0, 15));
            tid   = pick_thread();
            depth = $urandom_range(1, 4);
            repeat (depth)
               offer(make_req(FUNC_LOCK, idx, 1'b1, tid, 1'b0, 1'b0, 4'd0));
            if ($urandom_range(0, 1) == 0)
               offer(make_req(FUNC_LOCK, idx, 1'b1, pick_thread(), 1'b0, 1'b0, 4'd0));
            repeat (depth)
               offer(make_req(FUNC_UNLOCK, idx, 1'b1, tid, 1'b0, 1'b0, 4'd0));
         end else begin
            offer(random_request());
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for the pipeline
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("mutex_lock_table_tb passed");
      else
         $display("mutex_lock_table_tb failed");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("mutex_lock_table_tb failed");
      $finish;
   end

endmodule
